// File: design/pfn_txt_pkg.sv
// Package for the page frame number text parser: phase and status codes,
// address constants and the character classification functions.
// Depends on nothing; used by page_frame_number_text_parser.
`default_nettype none

package pfn_txt_pkg;

    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned PAGE_SIZE  = 4096;
    localparam int unsigned ACC_W      = 64;
    localparam int unsigned PFN_W      = ACC_W - PAGE_SHIFT;
    localparam logic [ACC_W-1:0] ADDR_LIMIT = ~64'd0 - 64'(PAGE_SIZE);

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_ZERO   = 3'd1,
        PH_PREFIX = 3'd2,
        PH_BODY   = 3'd3,
        PH_TRAIL  = 3'd4,
        PH_ERROR  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } digit_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09);
    endfunction

    function automatic logic is_x(input logic [7:0] c);
        return (c == 8'h78) || (c == 8'h58);
    endfunction

    function automatic digit_t digit_of(input logic [7:0] c, input logic hex);
        digit_t d;
        d.ok    = 1'b0;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.ok    = 1'b1;
            d.value = 4'(c - 8'h30);
        end
        else if (hex && c >= 8'h61 && c <= 8'h66)
        begin
            d.ok    = 1'b1;
            d.value = 4'(c - 8'h61 + 8'd10);
        end
        else if (hex && c >= 8'h41 && c <= 8'h46)
        begin
            d.ok    = 1'b1;
            d.value = 4'(c - 8'h41 + 8'd10);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// File: design/page_frame_number_text_parser.sv
// Page frame number text parser: takes one character per request and gives
// one status, frame number and physical address per string.
// Depends on pfn_txt_pkg.
//
//   Channel | Handshake           | Payload
//   input   | in_valid, in_ready  | ch, has_char, last
//   output  | out_valid, out_ready| status, frame_number, phys_address
//
// Requests are taken while in_ready is high; the accumulator update by a constant
// multiply-add and the end-of-string checks sit between the state registers
// and the output register. The result of a string appears the cycle after
// its last request. A waiting result stalls input only while out_ready is
// low. Reset returns the parser to the leading whitespace phase.
`default_nettype none

module page_frame_number_text_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  ch,
    input  wire logic        has_char,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [51:0]      frame_number,
    output logic [63:0]      phys_address
);

    pfn_txt_pkg::phase_t  phase_reg, phase_next;
    logic                 hex_reg, hex_next;
    logic [63:0]          accum_reg, accum_next;
    logic                 saw_reg, saw_next;
    logic                 wrapped_reg, wrapped_next;

    logic                 out_valid_reg;
    pfn_txt_pkg::status_t status_reg, status_next;
    logic [51:0]          pfn_reg, pfn_next;
    logic [63:0]          addr_reg, addr_next;

    logic                 accept;
    pfn_txt_pkg::digit_t  dig;
    logic [67:0]          scaled;
    logic [67:0]          summed;
    logic                 end_phase;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign dig    = pfn_txt_pkg::digit_of(ch, hex_reg);
    assign scaled = hex_reg ? {accum_reg, 4'b0000}
                            : ({1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0});
    assign summed = scaled + {64'd0, dig.value};

    always_comb
    begin
        phase_next   = phase_reg;
        hex_next     = hex_reg;
        accum_next   = accum_reg;
        saw_next     = saw_reg;
        wrapped_next = wrapped_reg;
        if (has_char)
        begin
            case (phase_reg)
                pfn_txt_pkg::PH_LEAD,
                pfn_txt_pkg::PH_ZERO,
                pfn_txt_pkg::PH_BODY:
                begin
                    if (phase_reg == pfn_txt_pkg::PH_LEAD && pfn_txt_pkg::is_blank(ch))
                    begin
                        phase_next = pfn_txt_pkg::PH_LEAD;
                    end
                    else if (phase_reg == pfn_txt_pkg::PH_LEAD && ch == 8'h30)
                    begin
                        accum_next = 64'd0;
                        saw_next   = 1'b1;
                        phase_next = pfn_txt_pkg::PH_ZERO;
                    end
                    else if (phase_reg == pfn_txt_pkg::PH_ZERO && pfn_txt_pkg::is_x(ch))
                    begin
                        hex_next   = 1'b1;
                        accum_next = 64'd0;
                        saw_next   = 1'b0;
                        phase_next = pfn_txt_pkg::PH_PREFIX;
                    end
                    else if (pfn_txt_pkg::is_blank(ch))
                    begin
                        phase_next = pfn_txt_pkg::PH_TRAIL;
                    end
                    else if (!dig.ok)
                    begin
                        phase_next = pfn_txt_pkg::PH_ERROR;
                    end
                    else
                    begin
                        accum_next   = summed[63:0];
                        wrapped_next = wrapped_reg || (summed[67:64] != 4'd0);
                        saw_next     = 1'b1;
                        phase_next   = pfn_txt_pkg::PH_BODY;
                    end
                end
                pfn_txt_pkg::PH_PREFIX:
                begin
                    if (!dig.ok)
                    begin
                        phase_next = pfn_txt_pkg::PH_ERROR;
                    end
                    else
                    begin
                        accum_next   = summed[63:0];
                        wrapped_next = wrapped_reg || (summed[67:64] != 4'd0);
                        saw_next     = 1'b1;
                        phase_next   = pfn_txt_pkg::PH_BODY;
                    end
                end
                pfn_txt_pkg::PH_TRAIL:
                begin
                    if (!pfn_txt_pkg::is_blank(ch))
                    begin
                        phase_next = pfn_txt_pkg::PH_ERROR;
                    end
                end
                default:
                begin
                    phase_next = pfn_txt_pkg::PH_ERROR;
                end
            endcase
        end
    end

    always_comb
    begin
        end_phase = (phase_next == pfn_txt_pkg::PH_ZERO) ||
                    (phase_next == pfn_txt_pkg::PH_BODY) ||
                    (phase_next == pfn_txt_pkg::PH_TRAIL);
        status_next = pfn_txt_pkg::ST_INVALID;
        pfn_next    = 52'd0;
        addr_next   = 64'd0;
        if (end_phase && saw_next && !wrapped_next)
        begin
            if (accum_next[63:52] != 12'd0)
            begin
                status_next = pfn_txt_pkg::ST_OVERFLOW;
            end
            else if ({accum_next[51:0], 12'd0} > pfn_txt_pkg::ADDR_LIMIT)
            begin
                status_next = pfn_txt_pkg::ST_OVERFLOW;
            end
            else
            begin
                status_next = pfn_txt_pkg::ST_OK;
                pfn_next    = accum_next[51:0];
                addr_next   = {accum_next[51:0], 12'd0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pfn_txt_pkg::PH_LEAD;
            hex_reg       <= 1'b0;
            accum_reg     <= 64'd0;
            saw_reg       <= 1'b0;
            wrapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (last)
                begin
                    phase_reg   <= pfn_txt_pkg::PH_LEAD;
                    hex_reg     <= 1'b0;
                    accum_reg   <= 64'd0;
                    saw_reg     <= 1'b0;
                    wrapped_reg <= 1'b0;
                end
                else
                begin
                    phase_reg   <= phase_next;
                    hex_reg     <= hex_next;
                    accum_reg   <= accum_next;
                    saw_reg     <= saw_next;
                    wrapped_reg <= wrapped_next;
                end
            end
            if (accept && last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last)
        begin
            status_reg <= status_next;
            pfn_reg    <= pfn_next;
            addr_reg   <= addr_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign frame_number = pfn_reg;
    assign phys_address = addr_reg;

    // A successful result carries an address that is the frame number shifted up by twelve bits.
    a_addr_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pfn_txt_pkg::ST_OK |-> phys_address == {frame_number, 12'd0})
        else $error("address does not match frame number");

    // A failed result carries zero payload.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != pfn_txt_pkg::ST_OK |-> frame_number == 52'd0 && phys_address == 64'd0)
        else $error("failed result carries a value");

    // The end of a string leaves the parser ready for a fresh one.
    a_string_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> phase_reg == pfn_txt_pkg::PH_LEAD && accum_reg == 64'd0
                                          && !hex_reg && !saw_reg && !wrapped_reg)
        else $error("parser state not cleared after end of string");

    // A result is raised only by the end of a string.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && last))
        else $error("result without end of string");

endmodule

`default_nettype wire
